### rtl/core/fqpm_pkg.sv
// Shared types, codes and sizes for the FIFO queue with promote-minimum.
package fqpm_pkg;

	// Queue geometry and derived widths.
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int OCC_W       = 5;

	// Operation codes carried by a request.
	typedef enum logic [1:0] {
		FUNC_ENQ     = 2'd0,
		FUNC_DEQ     = 2'd1,
		FUNC_LIST    = 2'd2,
		FUNC_PROMOTE = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// How the walk index moves on the next cycle.
	typedef enum logic [2:0] {
		IDX_HOLD   = 3'd0,
		IDX_ZERO   = 3'd1,
		IDX_INC    = 3'd2,
		IDX_DEC    = 3'd3,
		IDX_MINPOS = 3'd4
	} idx_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    emit;
		status_t emit_status;
		logic    emit_list;
		logic    emit_last;
		logic    enq;
		logic    deq;
		idx_op_t idx_op;
		logic    scan;
		logic    shift_wr;
		logic    place_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  empty;
		logic  full;
		logic  out_free;
		logic  idx_last;
		logic  idx_zero;
		logic  minpos_zero;
	} sts_t;

endpackage

### rtl/core/fqpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/fqpm_datapath.sv
// Datapath: slot storage, head and count, walk index, minimum search and result register.
module fqpm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fqpm_pkg::cmd_t                cmd,
	output fqpm_pkg::sts_t                sts,
	input  logic [1:0]                    func,
	input  logic signed [31:0]            item_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic signed [31:0]            out_value,
	output logic                          last_result,
	output logic [4:0]                    occupancy
);

	import fqpm_pkg::*;

	// Circular add of two slot offsets, result below the depth.
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
						      input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
			s = s - (IDX_W+1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	logic [1:0]        func_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_d;
	logic [DATA_W-1:0] min_q;
	logic [IDX_W-1:0]  pos_q;
	logic [DATA_W-1:0] new_min;
	logic [IDX_W-1:0]  new_pos;
	logic [DATA_W-1:0] rd_data;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] out_value_q;
	logic              last_q;
	logic [OCC_W-1:0]  occ_q;
	logic              out_free;

	// Slot storage.
	fqpm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Latched request.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q  <= func;
			value_q <= item_value;
		end
	end

	// Next walk index; the read address follows it so the read data lines up with the registered index.
	always_comb begin
		case (cmd.idx_op)
			IDX_HOLD:   idx_d = idx_q;
			IDX_ZERO:   idx_d = '0;
			IDX_INC:    idx_d = idx_q + 1'b1;
			IDX_DEC:    idx_d = idx_q - 1'b1;
			IDX_MINPOS: idx_d = new_pos - 1'b1;
			default:    idx_d = idx_q;
		endcase
	end

	assign rd_addr = wrap_add(head_q, idx_d);

	// Running minimum; the first smallest value wins on ties.
	always_comb begin
		new_min = min_q;
		new_pos = pos_q;
		if (idx_q == '0) begin
			new_min = rd_data;
			new_pos = '0;
		end else if ($signed(rd_data) < $signed(min_q)) begin
			new_min = rd_data;
			new_pos = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			min_q <= new_min;
			pos_q <= new_pos;
		end
	end

	// Single write port: append, shift one entry towards the tail, or place the minimum.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = min_q;
		if (cmd.enq) begin
			wr_en   = 1'b1;
			wr_addr = wrap_add(head_q, count_q[IDX_W-1:0]);
			wr_data = value_q;
		end else if (cmd.shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = wrap_add(head_q, idx_q + 1'b1);
			wr_data = rd_data;
		end else if (cmd.place_wr) begin
			wr_en   = 1'b1;
			wr_addr = head_q;
			wr_data = min_q;
		end
	end

	// Occupancy after the current operation.
	always_comb begin
		count_d = count_q;
		if (cmd.enq) begin
			count_d = count_q + 1'b1;
		end else if (cmd.deq) begin
			count_d = count_q - 1'b1;
		end
	end

	// Head, count and walk index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			count_q <= count_d;
			idx_q   <= idx_d;
			if (cmd.deq) begin
				head_q <= wrap_add(head_q, IDX_W'(1));
			end
		end
	end

	// Result register: it takes a new result whenever the old one leaves or is absent.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= cmd.emit_status;
			out_value_q <= cmd.emit_list ? rd_data : '0;
			last_q      <= cmd.emit_last;
			occ_q       <= OCC_W'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_value   = out_value_q;
	assign last_result = last_q;
	assign occupancy   = occ_q;

	// Status towards the controller.
	assign sts.func        = func_t'(func_q);
	assign sts.empty       = (count_q == '0);
	assign sts.full        = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.out_free    = out_free;
	assign sts.idx_last    = ((CNT_W'(idx_q) + 1'b1) == count_q);
	assign sts.idx_zero    = (idx_q == '0);
	assign sts.minpos_zero = (new_pos == '0);

endmodule

### rtl/core/fqpm_ctrl.sv
// Controller: sequences each request through the datapath.
module fqpm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fqpm_pkg::sts_t sts,
	output fqpm_pkg::cmd_t cmd
);

	import fqpm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_LIST  = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_PLACE = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.emit_status = ST_OK;
		cmd.emit_last   = 1'b1;
		cmd.idx_op      = IDX_HOLD;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.func)
					FUNC_ENQ: begin
						if (sts.out_free) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = sts.full ? ST_FULL : ST_OK;
							cmd.enq         = !sts.full;
							state_d         = S_IDLE;
						end
					end
					FUNC_DEQ: begin
						if (sts.out_free) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = sts.empty ? ST_EMPTY : ST_OK;
							cmd.deq         = !sts.empty;
							state_d         = S_IDLE;
						end
					end
					FUNC_LIST, FUNC_PROMOTE: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_EMPTY;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = (sts.func == FUNC_LIST) ? S_LIST : S_SCAN;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			// One entry per cycle while the result register keeps draining.
			S_LIST: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_list = 1'b1;
					cmd.emit_last = sts.idx_last;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
					end
				end
			end
			// Walk every entry to find the first smallest one.
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.idx_last) begin
					if (sts.minpos_zero) begin
						state_d = S_RESP;
					end else begin
						cmd.idx_op = IDX_MINPOS;
						state_d    = S_SHIFT;
					end
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			// Move the entries ahead of the minimum one place towards the tail.
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (sts.idx_zero) begin
					state_d = S_PLACE;
				end else begin
					cmd.idx_op = IDX_DEC;
				end
			end
			S_PLACE: begin
				cmd.place_wr = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/fifo_queue_with_promote_min_unit.sv
// Bounded FIFO of signed 32-bit values with enqueue, dequeue, list and promote-minimum.
// The unit takes one request at a time and holds QUEUE_DEPTH entries in a RAM with one
// write port and one registered read port. A request is accepted in the idle cycle and
// executed from the next; a list gives one result per entry, one result per cycle while
// the result side keeps up. Promote-minimum scans all N entries, one per RAM read;
// unless the minimum is already the head, each of the P entries ahead of it, P being
// its distance from the head, is moved by one read and one write, and the minimum is
// then placed at the head. Every request ends with one result marked as last, and any
// cycle that would emit a result waits while the previous result is still held by the
// consumer. The result register lets a new request be accepted while the previous
// result still waits.
module fifo_queue_with_promote_min_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic               last_result,
	output logic [4:0]         occupancy
);

	import fqpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fqpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fqpm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.item_value  (item_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_value   (out_value),
		.last_result (last_result),
		.occupancy   (occupancy)
	);

endmodule

### rtl/core/fqpm_checker.sv
// Port-level checks of the queue unit and their binding to it.
module fqpm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] out_value,
	input logic               last_result,
	input logic [4:0]         occupancy
);

	import fqpm_pkg::*;

	// A result held back by the consumer stays unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value)
			&& $stable(last_result) && $stable(occupancy))
		else $error("stalled result changed");

	// Error results are single, valueless results.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last_result && out_value == '0)
		else $error("error result not single or carries a value");

	// A dropped enqueue only happens on a full queue.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("full status with queue not full");

	// An empty status only happens on an empty queue.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty status with entries held");

	// Requests are taken one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken straight after the first");

endmodule

bind fifo_queue_with_promote_min_unit fqpm_checker u_fqpm_checker (.*);

### tb/sv/fifo_queue_with_promote_min_unit_tb.sv
// Self-checking testbench for the FIFO queue with promote-minimum, with a scoreboard class.
module fifo_queue_with_promote_min_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fqpm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	// Values that fill the queue behind the first entry; the most negative one sits at the tail.
	localparam logic signed [31:0] FILL_VALUES [15] = '{
		32'sd0, 32'sd1, -32'sd3, 32'sd5, -32'sd3, 32'sd2, -32'sd1, 32'sd1000,
		32'sd77, 32'sd12, 32'sd123456, -32'sd3, 32'sd4, 32'sh5555_5555, 32'sh8000_0000
	};

	// One expected result as it leaves the block.
	typedef struct packed {
		status_t          status;
		logic [DATA_W-1:0] value;
		logic             last;
		logic [OCC_W-1:0] occ;
	} queue_result_t;

	// Mirror of the queue contents and the results that each request should produce.
	class queue_scoreboard;
		logic [DATA_W-1:0] slots [QUEUE_DEPTH];
		int head = 0;
		int count = 0;
		int failures = 0;
		queue_result_t awaited[$];

		function void push_result(status_t st, logic [DATA_W-1:0] v, logic last);
			queue_result_t r;
			r.status = st;
			r.value = v;
			r.last = last;
			r.occ = count[OCC_W-1:0];
			awaited.push_back(r);
		endfunction

		// Applies an accepted request to the mirror and queues its results.
		function void note_request(func_t f, logic [DATA_W-1:0] v);
			int i;
			int min_pos;
			logic signed [DATA_W-1:0] min_val;
			case (f)
				FUNC_ENQ: begin
					if (count >= QUEUE_DEPTH) begin
						push_result(ST_FULL, '0, 1'b1);
					end else begin
						slots[(head + count) % QUEUE_DEPTH] = v;
						count++;
						push_result(ST_OK, '0, 1'b1);
					end
				end
				FUNC_DEQ: begin
					if (count == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						head = (head + 1) % QUEUE_DEPTH;
						count--;
						push_result(ST_OK, '0, 1'b1);
					end
				end
				FUNC_LIST: begin
					if (count == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						for (i = 0; i < count; i++)
							push_result(ST_OK, slots[(head + i) % QUEUE_DEPTH], i == count - 1);
					end
				end
				default: begin
					if (count == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						// The first smallest entry wins; those ahead of it move back by one.
						min_pos = 0;
						min_val = slots[head];
						for (i = 1; i < count; i++) begin
							if ($signed(slots[(head + i) % QUEUE_DEPTH]) < min_val) begin
								min_val = slots[(head + i) % QUEUE_DEPTH];
								min_pos = i;
							end
						end
						for (i = min_pos; i > 0; i--)
							slots[(head + i) % QUEUE_DEPTH] = slots[(head + i - 1) % QUEUE_DEPTH];
						slots[head] = min_val;
						push_result(ST_OK, '0, 1'b1);
					end
				end
			endcase
		endfunction

		// Compares one accepted result with the oldest one awaited.
		function void check_result(status_t st, logic [DATA_W-1:0] v, logic last,
				logic [OCC_W-1:0] occ);
			queue_result_t e;
			if (awaited.size() == 0) begin
				failures++;
				$error("unexpected result: status %0d, out_value %0d", st, $signed(v));
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status) begin
				failures++;
				$error("status: expected %0d, actual %0d", e.status, st);
			end
			if (v !== e.value) begin
				failures++;
				$error("out_value: expected %0d, actual %0d", $signed(e.value), $signed(v));
			end
			if (last !== e.last) begin
				failures++;
				$error("last_result: expected %0d, actual %0d", e.last, last);
			end
			if (occ !== e.occ) begin
				failures++;
				$error("occupancy: expected %0d, actual %0d", e.occ, occ);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic signed [31:0] item_value;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic signed [31:0] out_value;
	logic last_result;
	logic [4:0] occupancy;

	int send_idle_pct = 19;
	int recv_idle_pct = 79;
	int cycle_count = 0;
	queue_scoreboard sb = new;

	fifo_queue_with_promote_min_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_value(out_value),
		.last_result(last_result),
		.occupancy(occupancy)
	);

	always #2 clk = ~clk;

	// The result side stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Results are sampled at the falling edge, where every handshake signal has settled.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status_t'(status), out_value, last_result, occupancy);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Offers one request and returns at the rising edge that accepts it; valid stays high.
	task automatic send_request(input func_t f, input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		item_value <= v;
		do @(negedge clk); while (!in_ready);
		sb.note_request(f, v);
		@(posedge clk);
	endtask

	// Holds off the request side until every awaited result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic func_t pick_func(int enq_pct, int deq_pct, int list_pct);
		int r;
		r = $urandom_range(99);
		if (r < enq_pct)
			return FUNC_ENQ;
		if (r < enq_pct + deq_pct)
			return FUNC_DEQ;
		if (r < enq_pct + deq_pct + list_pct)
			return FUNC_LIST;
		return FUNC_PROMOTE;
	endfunction

	// Mostly random words, with extremes and a narrow band that produces ties.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return $urandom_range(6) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input int enq_pct,
			input int deq_pct, input int list_pct, input int n);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n)
			send_request(pick_func(enq_pct, deq_pct, list_pct), pick_value());
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ENQ;
		item_value <= '0;
		out_ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests on an empty queue, then a single entry.
		send_request(FUNC_LIST, 32'h0);
		send_request(FUNC_DEQ, 32'hffff_ffff);
		send_request(FUNC_PROMOTE, 32'ha5a5_a5a5);
		send_request(FUNC_ENQ, 32'h7fff_ffff);
		send_request(FUNC_PROMOTE, 32'h0);

		// Fill to capacity, then overflow and list the full queue.
		foreach (FILL_VALUES[i])
			send_request(FUNC_ENQ, FILL_VALUES[i]);
		send_request(FUNC_ENQ, 32'h1234_5678);
		send_request(FUNC_LIST, 32'h0);

		// Minimum at the tail, then a tie on the minimum, then minimum already at the head.
		send_request(FUNC_PROMOTE, 32'h0);
		send_request(FUNC_DEQ, 32'h0);
		send_request(FUNC_PROMOTE, 32'h0);
		send_request(FUNC_PROMOTE, 32'h0);
		send_request(FUNC_LIST, 32'h0);

		// Random traffic in three idling phases; the awaited results are drained once in between.
		run_phase(19, 79, 55, 15, 12, 52);
		drain_results();
		run_phase(79, 19, 35, 35, 12, 52);
		run_phase(0, 0, 48, 22, 10, 52);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
